// File: rtl/hsvrgb_pkg.sv
package hsvrgb_pkg;

  // Field widths
  localparam int unsigned HueW  = 13;
  localparam int unsigned ChanW = 8;

  // Hue fixed point: fraction bits below one degree
  localparam int unsigned HueFracBits = 4;
  localparam int unsigned SectorUnits = 60 << HueFracBits;
  localparam int unsigned TurnUnits   = 360 << HueFracBits;
  localparam int unsigned NumSectors  = 6;
  localparam int unsigned RemW        = $clog2(SectorUnits);

  // Full scale of one sector times 255: 255 * 15 * 2^(HueFracBits+2)
  localparam int unsigned FullScale = 255 * SectorUnits;
  localparam int unsigned FactorW   = $clog2(FullScale + 1);
  localparam int unsigned ProdW     = 2 * ChanW;
  localparam int unsigned NumW      = FactorW + ChanW;

  // Division by FullScale: shift out the power of two, then /15, then /255
  localparam int unsigned ShiftDiv    = HueFracBits + 2;
  localparam int unsigned QuotW       = 20;
  localparam int unsigned Recip15Sh   = 24;
  localparam int unsigned Recip15     = ((1 << Recip15Sh) + 14) / 15;
  localparam int unsigned Recip15W    = $clog2(Recip15 + 1);
  localparam int unsigned RecipProdW  = QuotW + Recip15W;
  localparam int unsigned LevelW      = 16;

  typedef enum logic [2:0] {
    SecRedYellow   = 3'd0,
    SecYellowGreen = 3'd1,
    SecGreenCyan   = 3'd2,
    SecCyanBlue    = 3'd3,
    SecBlueMagenta = 3'd4,
    SecMagentaRed  = 3'd5
  } sector_e;

  typedef struct packed {
    logic [HueW-1:0]  hue;
    logic [ChanW-1:0] saturation;
    logic [ChanW-1:0] brightness;
  } hsv_t;

  typedef struct packed {
    logic [ChanW-1:0] red;
    logic [ChanW-1:0] green;
    logic [ChanW-1:0] blue;
  } rgb_t;

  // After sector split
  typedef struct packed {
    sector_e          sector;
    logic [RemW-1:0]  rem;
    logic [ChanW-1:0] sat;
    logic [ChanW-1:0] val;
  } sec_t;

  // After ramp factors
  typedef struct packed {
    sector_e            sector;
    logic [FactorW-1:0] fq;
    logic [FactorW-1:0] ft;
    logic [ProdW-1:0]   pprod;
    logic [ChanW-1:0]   val;
  } fac_t;

  // After scaling by brightness
  typedef struct packed {
    sector_e          sector;
    logic [NumW-1:0]  nq;
    logic [NumW-1:0]  nt;
    logic [ChanW-1:0] p;
    logic [ChanW-1:0] val;
  } num_t;

  // After division by the sector scale, before the final /255
  typedef struct packed {
    sector_e           sector;
    logic [LevelW-1:0] zq;
    logic [LevelW-1:0] zt;
    logic [ChanW-1:0]  p;
    logic [ChanW-1:0]  val;
  } lvl_t;

  // Exact floor(x/255) for x up to 255*255
  function automatic logic [ChanW-1:0] div255(input logic [ProdW-1:0] x);
    logic [ProdW:0] s;
    s = {1'b0, x} + (ProdW+1)'(x >> ChanW) + (ProdW+1)'(1);
    return s[ProdW-1:ChanW];
  endfunction

endpackage

// File: rtl/hsvrgb_sector.sv
module hsvrgb_sector (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                valid_i,
  input  hsvrgb_pkg::hsv_t    hsv_i,
  output logic                valid_o,
  output hsvrgb_pkg::sec_t    sec_o
);

  logic             valid_q;
  hsvrgb_pkg::sec_t sec_d, sec_q;
  logic [31:0]      hue_w;
  logic [2:0]       cnt;
  logic [31:0]      base;

  // Wrap, then find the sector by parallel compares against sector bounds
  always_comb begin
    hue_w = 32'(hsv_i.hue);
    if (hue_w >= 32'(hsvrgb_pkg::TurnUnits)) begin
      hue_w = '0;
    end
    cnt = '0;
    for (int k = 1; k < hsvrgb_pkg::NumSectors; k++) begin
      if (hue_w >= 32'(k * hsvrgb_pkg::SectorUnits)) begin
        cnt = 3'(k);
      end
    end
    base = 32'(cnt) * 32'(hsvrgb_pkg::SectorUnits);
    sec_d.sector = hsvrgb_pkg::sector_e'(cnt);
    sec_d.rem    = hsvrgb_pkg::RemW'(hue_w - base);
    sec_d.sat    = hsv_i.saturation;
    sec_d.val    = hsv_i.brightness;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    sec_q <= sec_d;
  end

  assign valid_o = valid_q;
  assign sec_o   = sec_q;

endmodule

// File: rtl/hsvrgb_scale.sv
module hsvrgb_scale (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                valid_i,
  input  hsvrgb_pkg::sec_t    sec_i,
  output logic                valid_o,
  output hsvrgb_pkg::num_t    num_o
);

  logic [1:0]                         valid_q;
  hsvrgb_pkg::fac_t                   fac_d, fac_q;
  hsvrgb_pkg::num_t                   num_d, num_q;
  logic [hsvrgb_pkg::FactorW-1:0]     srem;
  logic [hsvrgb_pkg::FactorW-1:0]     sfull;

  // Stage 1: ramp factors 255*D - S*rem and 255*D - S*(D-rem)
  always_comb begin
    srem  = hsvrgb_pkg::FactorW'(sec_i.sat) * hsvrgb_pkg::FactorW'(sec_i.rem);
    sfull = hsvrgb_pkg::FactorW'(sec_i.sat) * hsvrgb_pkg::FactorW'(hsvrgb_pkg::SectorUnits);
    fac_d.sector = sec_i.sector;
    fac_d.fq     = hsvrgb_pkg::FactorW'(hsvrgb_pkg::FullScale) - srem;
    fac_d.ft     = hsvrgb_pkg::FactorW'(hsvrgb_pkg::FullScale) - sfull + srem;
    fac_d.pprod  = hsvrgb_pkg::ProdW'(sec_i.val) *
                   hsvrgb_pkg::ProdW'(8'd255 - sec_i.sat);
    fac_d.val    = sec_i.val;
  end

  // Stage 2: scale by brightness; P finishes here
  always_comb begin
    num_d.sector = fac_q.sector;
    num_d.nq     = hsvrgb_pkg::NumW'(fac_q.val) * hsvrgb_pkg::NumW'(fac_q.fq);
    num_d.nt     = hsvrgb_pkg::NumW'(fac_q.val) * hsvrgb_pkg::NumW'(fac_q.ft);
    num_d.p      = hsvrgb_pkg::div255(fac_q.pprod);
    num_d.val    = fac_q.val;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= {valid_q[0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    fac_q <= fac_d;
    num_q <= num_d;
  end

  assign valid_o = valid_q[1];
  assign num_o   = num_q;

endmodule

// File: rtl/hsvrgb_div.sv
module hsvrgb_div (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                valid_i,
  input  hsvrgb_pkg::num_t    num_i,
  output logic                valid_o,
  output hsvrgb_pkg::lvl_t    lvl_o
);

  logic                                  valid_q;
  hsvrgb_pkg::lvl_t                      lvl_d, lvl_q;
  logic [hsvrgb_pkg::QuotW-1:0]          yq, yt;
  logic [hsvrgb_pkg::RecipProdW-1:0]     mq, mt;
  logic [hsvrgb_pkg::Recip15W-1:0]       recip;

  // Drop the power-of-two part of the scale, then /15 by reciprocal multiply
  always_comb begin
    recip = hsvrgb_pkg::Recip15W'(hsvrgb_pkg::Recip15);
    yq    = hsvrgb_pkg::QuotW'(num_i.nq >> hsvrgb_pkg::ShiftDiv);
    yt    = hsvrgb_pkg::QuotW'(num_i.nt >> hsvrgb_pkg::ShiftDiv);
    mq    = hsvrgb_pkg::RecipProdW'(yq) * hsvrgb_pkg::RecipProdW'(recip);
    mt    = hsvrgb_pkg::RecipProdW'(yt) * hsvrgb_pkg::RecipProdW'(recip);
    lvl_d.sector = num_i.sector;
    lvl_d.zq     = hsvrgb_pkg::LevelW'(mq >> hsvrgb_pkg::Recip15Sh);
    lvl_d.zt     = hsvrgb_pkg::LevelW'(mt >> hsvrgb_pkg::Recip15Sh);
    lvl_d.p      = num_i.p;
    lvl_d.val    = num_i.val;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    lvl_q <= lvl_d;
  end

  assign valid_o = valid_q;
  assign lvl_o   = lvl_q;

endmodule

// File: rtl/hsv_to_rgb_converter.sv
// HSV to RGB converter, fully pipelined. A hue/saturation/value triple is
// taken on every cycle that start is high; busy never rises, so the block
// accepts one item per clock with no gaps. Each result appears on rgb_o
// for one cycle with done_o high, after its register stages (sector split,
// ramp factors, brightness scaling, divide by the sector scale, final
// /255 and channel select), in input order. The receiver
// cannot stall the pipeline and must take every result as it comes. Hue is
// in 1/16 degree units and wraps to zero at 360 degrees or more; channels
// are truncated toward zero.
module hsv_to_rgb_converter (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  hsvrgb_pkg::hsv_t    hsv_i,
  output logic                done_o,
  output hsvrgb_pkg::rgb_t    rgb_o
);

  logic             sec_valid, num_valid, lvl_valid;
  hsvrgb_pkg::sec_t sec;
  hsvrgb_pkg::num_t num;
  hsvrgb_pkg::lvl_t lvl;

  logic                         done_q;
  hsvrgb_pkg::rgb_t             rgb_d, rgb_q;
  logic [hsvrgb_pkg::ChanW-1:0] q_lvl, t_lvl;

  // Pipeline always advances
  assign busy = 1'b0;

  hsvrgb_sector u_sector (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (start),
    .hsv_i   (hsv_i),
    .valid_o (sec_valid),
    .sec_o   (sec)
  );

  hsvrgb_scale u_scale (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (sec_valid),
    .sec_i   (sec),
    .valid_o (num_valid),
    .num_o   (num)
  );

  hsvrgb_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (num_valid),
    .num_i   (num),
    .valid_o (lvl_valid),
    .lvl_o   (lvl)
  );

  // Final /255 and per-sector channel assignment
  always_comb begin
    q_lvl = hsvrgb_pkg::div255(lvl.zq);
    t_lvl = hsvrgb_pkg::div255(lvl.zt);
    unique case (lvl.sector)
      hsvrgb_pkg::SecRedYellow: begin
        rgb_d = '{red: lvl.val, green: t_lvl, blue: lvl.p};
      end
      hsvrgb_pkg::SecYellowGreen: begin
        rgb_d = '{red: q_lvl, green: lvl.val, blue: lvl.p};
      end
      hsvrgb_pkg::SecGreenCyan: begin
        rgb_d = '{red: lvl.p, green: lvl.val, blue: t_lvl};
      end
      hsvrgb_pkg::SecCyanBlue: begin
        rgb_d = '{red: lvl.p, green: q_lvl, blue: lvl.val};
      end
      hsvrgb_pkg::SecBlueMagenta: begin
        rgb_d = '{red: t_lvl, green: lvl.p, blue: lvl.val};
      end
      default: begin
        rgb_d = '{red: lvl.val, green: lvl.p, blue: q_lvl};
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= lvl_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    rgb_q <= rgb_d;
  end

  assign done_o = done_q;
  assign rgb_o  = rgb_q;

endmodule
